// ===== design/linear_region_detector_assert.svh =====
// Assertion macros shared by the checker of the linear region detector.
// Needs nothing else; included by bare file name.
`ifndef LINEAR_REGION_DETECTOR_ASSERT_SVH
`define LINEAR_REGION_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LRD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrd: implication failed");

// Next-cycle implication, disabled while reset is low.
`define LRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrd: next-cycle implication failed");

`endif

// ===== design/lrd_pkg.sv =====
// Shared widths, limits and types of the linear region detector.
// No dependencies.
package lrd_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned SumW    = 48;
  localparam int unsigned CountW  = 16;
  localparam int unsigned RatioW  = 16;
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned RhsW    = 66;
  localparam int unsigned DivCntW = $clog2(SumW);

  localparam logic [CountW-1:0] MaxListLength = 16'd65535;
  localparam logic [RatioW-1:0] RatioReset    = 16'd256;

  typedef struct packed {
    logic               done;
    logic [SampleW-1:0] quotient;
  } div_result_t;

endpackage

// ===== design/lrd_mul.sv =====
// Shared signed multiplier of the linear region detector, registered output.
// Uses lrd_pkg.
module lrd_mul (
  input  logic                              clk_i,
  input  logic signed [lrd_pkg::MulAW-1:0]  op_a_i,
  input  logic signed [lrd_pkg::MulBW-1:0]  op_b_i,
  output logic signed [lrd_pkg::ProdW-1:0]  prod_o
);

  logic signed [lrd_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== design/lrd_div.sv =====
// Restoring divider, one quotient bit per cycle: signed sum by unsigned count.
// Uses lrd_pkg; quotient truncates toward zero.
module lrd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [lrd_pkg::SumW-1:0]   dividend_i,
  input  logic [lrd_pkg::CountW-1:0]        divisor_i,
  output lrd_pkg::div_result_t              result_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [lrd_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [lrd_pkg::CountW-1:0]    rem_q, rem_d;
  logic [lrd_pkg::SumW-1:0]      quo_q, quo_d;
  logic [lrd_pkg::CountW-1:0]    dvs_q, dvs_d;
  logic                          neg_q, neg_d;
  logic [lrd_pkg::CountW:0]      trial;
  logic [lrd_pkg::SumW-1:0]      quo_neg;

  assign trial   = {rem_q, quo_q[lrd_pkg::SumW-1]};
  assign quo_neg = ~quo_q + 1'b1;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      neg_d  = dividend_i[lrd_pkg::SumW-1];
      quo_d  = dividend_i[lrd_pkg::SumW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[lrd_pkg::SumW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d    = lrd_pkg::CountW'(trial - {1'b0, dvs_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[lrd_pkg::CountW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lrd_pkg::DivCntW'(lrd_pkg::SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign result_o.done     = done_q;
  assign result_o.quotient = neg_q ? quo_neg[lrd_pkg::SampleW-1:0]
                                   : quo_q[lrd_pkg::SampleW-1:0];

endmodule

// ===== design/linear_region_detector.sv =====
// Linear region detector, top level. Uses lrd_pkg, lrd_mul and lrd_div.
// A counted sample beat holds in_stall_o high through three multiplier passes,
// accumulate and compare, so no new sample is taken until it is done. Ignored beats do not stall.
// A beat that yields a result then waits for the 48 divider steps, the S_DIV wait for done
// and the S_DONE output load, plus any output stall; an over-limit list skips the passes.
// rst_ni (async, active low) clears list state, sequencer, out_valid_o; ratio to 256.
module linear_region_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lrd_pkg::SampleW-1:0]  sample_i,
  input  logic                                last_sample_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lrd_pkg::CountW-1:0]          region_length_o,
  output logic signed [lrd_pkg::SampleW-1:0]  region_mean_o,
  output logic                                spread_exceeded_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [1:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL_LHS = 3'd1; // spread * count
  localparam logic [2:0] S_MUL_LO  = 3'd2; // ratio * sum[23:0]
  localparam logic [2:0] S_MUL_HI  = 3'd3; // ratio * sum[47:24]
  localparam logic [2:0] S_ACC     = 3'd4; // fold high partial into rhs
  localparam logic [2:0] S_CMP     = 3'd5; // spread*count<<8 > ratio*sum
  localparam logic [2:0] S_DIV     = 3'd6; // wait for mean
  localparam logic [2:0] S_DONE    = 3'd7; // wait for free output register

  logic [2:0]                         state_q, state_d;
  logic [lrd_pkg::RatioW-1:0]         ratio_q;
  logic signed [lrd_pkg::SumW-1:0]    sum_q, sum_d;
  logic signed [lrd_pkg::SampleW-1:0] min_q, min_d, max_q, max_d;
  logic [lrd_pkg::CountW-1:0]         count_q, count_d;
  logic                               given_q, given_d;
  logic                               last_q, last_d;
  logic                               exceeded_q, exceeded_d;
  logic signed [lrd_pkg::ProdW-1:0]   lhs_q, lhs_d;
  logic signed [lrd_pkg::RhsW-1:0]    rhs_q, rhs_d;
  logic                               ovalid_q, ovalid_d;
  logic [lrd_pkg::CountW-1:0]         olen_q, olen_d;
  logic signed [lrd_pkg::SampleW-1:0] omean_q, omean_d;
  logic                               oexc_q, oexc_d;

  logic                               in_acc;
  logic                               out_free;
  logic                               div_start;
  logic signed [lrd_pkg::MulAW-1:0]   spread;
  logic signed [lrd_pkg::MulAW-1:0]   mul_a;
  logic signed [lrd_pkg::MulBW-1:0]   mul_b;
  logic signed [lrd_pkg::ProdW-1:0]   prod;
  logic signed [lrd_pkg::RhsW-1:0]    prod_ext;
  logic signed [lrd_pkg::RhsW-1:0]    lhs_ext;
  logic signed [lrd_pkg::SumW-1:0]    sample_ext;
  lrd_pkg::div_result_t               div_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ovalid_q || !out_stall_i;

  assign sample_ext = {{(lrd_pkg::SumW - lrd_pkg::SampleW){sample_i[lrd_pkg::SampleW-1]}},
                       sample_i};
  assign spread     = {max_q[lrd_pkg::SampleW-1], max_q} - {min_q[lrd_pkg::SampleW-1], min_q};
  assign prod_ext   = {{(lrd_pkg::RhsW - lrd_pkg::ProdW){prod[lrd_pkg::ProdW-1]}}, prod};
  assign lhs_ext    = {8'b0, lhs_q, 8'b0};

  // Operand select for the shared multiplier; sum is split into 24-bit halves.
  always_comb begin
    case (state_q)
      S_MUL_LHS: begin
        mul_a = spread;
        mul_b = {1'b0, count_q};
      end
      S_MUL_LO: begin
        mul_a = {9'b0, sum_q[23:0]};
        mul_b = {1'b0, ratio_q};
      end
      default: begin
        mul_a = {{9{sum_q[lrd_pkg::SumW-1]}}, sum_q[lrd_pkg::SumW-1:24]};
        mul_b = {1'b0, ratio_q};
      end
    endcase
  end

  lrd_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  lrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .result_o   (div_res)
  );

  always_comb begin
    state_d    = state_q;
    sum_d      = sum_q;
    min_d      = min_q;
    max_d      = max_q;
    count_d    = count_q;
    given_d    = given_q;
    last_d     = last_q;
    exceeded_d = exceeded_q;
    lhs_d      = lhs_q;
    rhs_d      = rhs_q;
    olen_d     = olen_q;
    omean_d    = omean_q;
    oexc_d     = oexc_q;
    div_start  = 1'b0;
    ovalid_d   = ovalid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d = last_sample_i;
          if (!given_q && (count_q < lrd_pkg::MaxListLength)) begin
            // First sample of a list loads min and max.
            if (count_q == '0) begin
              min_d = sample_i;
              max_d = sample_i;
            end else begin
              if (sample_i < min_q) min_d = sample_i;
              if (sample_i > max_q) max_d = sample_i;
            end
            sum_d   = sum_q + sample_ext;
            count_d = count_q + 1'b1;
            state_d = S_MUL_LHS;
          end else if (last_sample_i) begin
            if (!given_q) begin
              // List over the length limit ends without a break.
              exceeded_d = 1'b0;
              div_start  = 1'b1;
              state_d    = S_DIV;
            end else begin
              sum_d   = '0;
              min_d   = '0;
              max_d   = '0;
              count_d = '0;
              given_d = 1'b0;
            end
          end
        end
      end
      S_MUL_LHS: begin
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        lhs_d   = prod;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        rhs_d   = prod_ext;
        state_d = S_ACC;
      end
      S_ACC: begin
        rhs_d   = rhs_q + (prod_ext <<< 24);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (lhs_ext > rhs_q) begin
          given_d    = 1'b1;
          exceeded_d = 1'b1;
          div_start  = 1'b1;
          state_d    = S_DIV;
        end else if (last_q) begin
          exceeded_d = 1'b0;
          div_start  = 1'b1;
          state_d    = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_res.done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          olen_d   = count_q;
          omean_d  = div_res.quotient;
          oexc_d   = exceeded_q;
          if (last_q) begin
            sum_d   = '0;
            min_d   = '0;
            max_d   = '0;
            count_d = '0;
            given_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ratio_q  <= lrd_pkg::RatioReset;
      sum_q    <= '0;
      min_q    <= '0;
      max_q    <= '0;
      count_q  <= '0;
      given_q  <= 1'b0;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      min_q    <= min_d;
      max_q    <= max_d;
      count_q  <= count_d;
      given_q  <= given_d;
      last_q   <= last_d;
      ovalid_q <= ovalid_d;
      // Single register: every write beat lands in ratio_q.
      if (psel && penable && pwrite) begin
        ratio_q <= pwdata[lrd_pkg::RatioW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exceeded_q <= exceeded_d;
    lhs_q      <= lhs_d;
    rhs_q      <= rhs_d;
    olen_q     <= olen_d;
    omean_q    <= omean_d;
    oexc_q     <= oexc_d;
  end

  assign out_valid_o       = ovalid_q;
  assign region_length_o   = olen_q;
  assign region_mean_o     = omean_q;
  assign spread_exceeded_o = oexc_q;

  assign prdata = {{(32 - lrd_pkg::RatioW){1'b0}}, ratio_q};
  assign pready = 1'b1;

  // paddr carries only byte-offset bits of the single word register.
  logic unused_addr;
  assign unused_addr = ^paddr;

endmodule

// ===== design/lrd_checker.sv =====
// Port-level checker for linear_region_detector, attached by bind.
// Uses linear_region_detector_assert.svh.
`include "linear_region_detector_assert.svh"

module lrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] region_length_o,
  input logic [31:0] region_mean_o,
  input logic        spread_exceeded_o,
  input logic        pready
);

  // Whole result payload, for the hold check.
  logic [48:0] out_word;
  assign out_word = {region_length_o, region_mean_o, spread_exceeded_o};

  `LRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `LRD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_word))
  `LRD_ASSERT_IMPLIES(a_len_nonzero, clk_i, rst_ni, out_valid_o, region_length_o != 16'd0)
  `LRD_ASSERT_IMPLIES(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))
  `LRD_ASSERT_IMPLIES(a_pready_high, clk_i, rst_ni, in_valid_i || !in_valid_i, pready)

endmodule

bind linear_region_detector lrd_checker u_lrd_checker (.*);
